>>> rtl/pmul_pkg.sv
// Shared types and constants for the polynomial multiplier.
package pmul_pkg;

    localparam int IN_COEF_W = 16;
    localparam int PROD_W    = 37;
    localparam int POWER_W   = 6;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN
    } state_t;

endpackage

>>> rtl/polynomial_multiply_top.sv
// Polynomial multiplier top level: operand load, convolution sequencer and result register.
//
// Usage:
//   Input channel (in_valid / in_stall): one coefficient per item, operand A
//   (func = 0) then operand B (func = 1), lowest power first, last_term on the
//   highest power of each operand. While loading, every valid item is taken.
//   B's last item starts the product. While it runs in_stall is high.
//   Output channel (out_valid / out_stall): product coefficients, power 0
//   upward, last_result on the final one, truncated if any coefficient was
//   dropped because its store was full.
//   Sequencing: each product coefficient k sums the term pairs with i + j = k,
//   issued one per cycle to a single multiply-accumulate fed by the two
//   operand RAM read ports; the read and product registers drain before the
//   sum is loaded. Loading resumes once the last coefficient is loaded.
//   A stalled result holds in the output register; the next coefficient is
//   accumulated meanwhile and waits for the register to free.
//   Reset clears term counts, flags and the sequencer; operand RAM contents
//   are not cleared and are never used before being written.
module polynomial_multiply_top #(
    parameter int MAX_TERMS  = 32,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  func,
    input  logic signed [pmul_pkg::IN_COEF_W-1:0] coefficient,
    input  logic                                  last_term,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pmul_pkg::PROD_W-1:0]    product_coefficient,
    output logic [pmul_pkg::POWER_W-1:0]          power,
    output logic                                  last_result,
    output logic                                  truncated
);

    import pmul_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int AW    = $clog2(MAX_TERMS);
    localparam int MW    = 2 * COEF_WIDTH;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]   cnt_b_reg, cnt_b_next;
    logic               done_a_reg, done_a_next;
    logic               ovf_reg, ovf_next;
    logic [POWER_W-1:0] k_reg, k_next;
    logic [POWER_W-1:0] i_reg, i_next;

    logic               rd_vld_reg;
    logic               mul_vld_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  acc_reg;

    logic               out_valid_reg;
    logic [PROD_W-1:0]  out_prod_reg;
    logic [POWER_W-1:0] out_power_reg;
    logic               out_last_reg;
    logic               out_trunc_reg;

    logic               in_take;
    logic               issue;
    logic               out_load;
    logic               out_free;
    logic               wr_a;
    logic               wr_b;
    logic [CNT_W-1:0]   a_base;
    logic [COEF_WIDTH+IN_COEF_W-1:0] coef_wide;
    logic [COEF_WIDTH-1:0] coef_w;

    logic               a_zero;
    logic               b_zero;
    logic [POWER_W-1:0] na_eff;
    logic [POWER_W-1:0] nb_eff;
    logic [POWER_W-1:0] n_m1;
    logic [POWER_W-1:0] i_hi;
    logic [POWER_W-1:0] k_inc;
    logic [POWER_W-1:0] i_lo_inc;
    logic [POWER_W-1:0] j_idx;
    logic               k_is_last;

    logic [COEF_WIDTH-1:0]    rd_a;
    logic [COEF_WIDTH-1:0]    rd_b;
    logic signed [COEF_WIDTH-1:0] op_a;
    logic signed [COEF_WIDTH-1:0] op_b;
    logic signed [MW-1:0]     mult;
    logic [MW+PROD_W-1:0]     mult_ext;

    // coefficient reduced to COEF_WIDTH bits; above 16 bits the top is zero
    assign coef_wide = {{COEF_WIDTH{1'b0}}, coefficient};
    assign coef_w    = coef_wide[COEF_WIDTH-1:0];

    assign in_stall = (state_reg != ST_LOAD);
    assign in_take  = in_valid && !in_stall;
    assign a_base   = done_a_reg ? '0 : cnt_a_reg;
    assign wr_a     = in_take && !func && (a_base < MAX_CNT);
    assign wr_b     = in_take && func && (cnt_b_reg < MAX_CNT);

    assign a_zero    = (cnt_a_reg == '0);
    assign b_zero    = (cnt_b_reg == '0);
    assign na_eff    = a_zero ? POWER_W'(1) : POWER_W'(cnt_a_reg);
    assign nb_eff    = b_zero ? POWER_W'(1) : POWER_W'(cnt_b_reg);
    assign n_m1      = na_eff + nb_eff - POWER_W'(2);
    assign i_hi      = (k_reg < na_eff) ? k_reg : na_eff - POWER_W'(1);
    assign k_inc     = k_reg + POWER_W'(1);
    assign i_lo_inc  = (k_inc >= nb_eff) ? k_inc - nb_eff + POWER_W'(1) : '0;
    assign j_idx     = k_reg - i_reg;
    assign k_is_last = (k_reg == n_m1);
    assign out_free  = !out_valid_reg || !out_stall;

    pmul_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (MAX_TERMS)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (a_base[AW-1:0]),
        .wr_data (coef_w),
        .rd_addr (i_reg[AW-1:0]),
        .rd_data (rd_a)
    );

    pmul_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (MAX_TERMS)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[AW-1:0]),
        .wr_data (coef_w),
        .rd_addr (j_idx[AW-1:0]),
        .rd_data (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            done_a_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            k_reg      <= '0;
            i_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            done_a_reg <= done_a_next;
            ovf_reg    <= ovf_next;
            k_reg      <= k_next;
            i_reg      <= i_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        done_a_next = done_a_reg;
        ovf_next    = ovf_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        issue       = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_take)
                begin
                    if (!func)
                    begin
                        cnt_a_next  = wr_a ? a_base + CNT_W'(1) : a_base;
                        ovf_next    = ovf_reg || !wr_a;
                        done_a_next = last_term;
                    end
                    else
                    begin
                        cnt_b_next = wr_b ? cnt_b_reg + CNT_W'(1) : cnt_b_reg;
                        ovf_next   = ovf_reg || !wr_b;
                        if (last_term)
                        begin
                            state_next = ST_MAC;
                            k_next     = '0;
                            i_next     = '0;
                        end
                    end
                end
            end
            ST_MAC:
            begin
                issue = 1'b1;
                if (i_reg == i_hi)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    i_next = i_reg + POWER_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg && out_free)
                begin
                    out_load = 1'b1;
                    if (k_is_last)
                    begin
                        state_next  = ST_LOAD;
                        cnt_a_next  = '0;
                        cnt_b_next  = '0;
                        done_a_next = 1'b0;
                        ovf_next    = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_MAC;
                        k_next     = k_inc;
                        i_next     = i_lo_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // an operand with no terms reads as a single zero
    assign op_a     = a_zero ? '0 : $signed(rd_a);
    assign op_b     = b_zero ? '0 : $signed(rd_b);
    assign mult     = op_a * op_b;
    assign mult_ext = {{PROD_W{mult[MW-1]}}, mult};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;
            if (out_load)
            begin
                acc_reg <= '0;
            end
            else if (mul_vld_reg)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mult_ext[PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_prod_reg  <= acc_reg;
            out_power_reg <= k_reg;
            out_last_reg  <= k_is_last;
            out_trunc_reg <= ovf_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign product_coefficient = $signed(out_prod_reg);
    assign power               = out_power_reg;
    assign last_result         = out_last_reg;
    assign truncated           = out_trunc_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= MAX_CNT) && (cnt_b_reg <= MAX_CNT))
        else $error("term count beyond store depth");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!rd_vld_reg && !mul_vld_reg && !issue))
        else $error("result taken with products in flight");

    a_power_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !k_is_last) |=> (k_reg == $past(k_inc)))
        else $error("power did not advance by one");

    a_product_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && k_is_last) |=> (cnt_a_reg == '0 && cnt_b_reg == '0 && !ovf_reg))
        else $error("state not cleared after product");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("stalled result overwritten");

endmodule

>>> rtl/pmul_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmul_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> verif/pmul_checker.sv
`timescale 1ns / 1ps
// Checker for the polynomial multiplier: tracks operand loads, predicts product terms, compares.
module pmul_checker #(
    parameter int MAX_TERMS  = 32,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  func,
    input  logic signed [pmul_pkg::IN_COEF_W-1:0] coefficient,
    input  logic                                  last_term,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [pmul_pkg::PROD_W-1:0]    product_coefficient,
    input  logic [pmul_pkg::POWER_W-1:0]          power,
    input  logic                                  last_result,
    input  logic                                  truncated,
    output int                                    fail_count,
    output int                                    pending
);

    import pmul_pkg::*;

    typedef struct packed {
        logic signed [PROD_W-1:0] value;
        logic [POWER_W-1:0]       power;
        logic                     is_last;
        logic                     trunc;
    } prod_term_t;

    prod_term_t      product_q[$];
    prod_term_t      got;
    prod_term_t      want;
    int              a_terms [MAX_TERMS];
    int              b_terms [MAX_TERMS];
    int              a_cnt;
    int              b_cnt;
    bit              a_done;
    bit              dropped;
    int              na;
    int              nb;
    int              nterms;
    int              j;
    int              coef;
    bit              a_zero;
    bit              b_zero;
    longint          acc;
    longint unsigned coef_u;

    task automatic report_mismatch(input string what, input prod_term_t exp_t,
                                   input prod_term_t act_t);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s: exp value=%0d power=%0d last=%0b trunc=%0b", $realtime, what,
                     exp_t.value, exp_t.power, exp_t.is_last, exp_t.trunc);
            $display("%0t: %s: got value=%0d power=%0d last=%0b trunc=%0b", $realtime, what,
                     act_t.value, act_t.power, act_t.is_last, act_t.trunc);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cnt      = 0;
            b_cnt      = 0;
            a_done     = 1'b0;
            dropped    = 1'b0;
            fail_count = 0;
            product_q.delete();
            pending   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                coef_u = {48'd0, coefficient};
                coef_u = coef_u & ((64'd1 << COEF_WIDTH) - 64'd1);
                if (coef_u[COEF_WIDTH-1])
                    coef = int'(longint'(coef_u) - (longint'(1) << COEF_WIDTH));
                else
                    coef = int'(coef_u);

                if (!func)
                begin
                    if (a_done)
                    begin
                        a_cnt  = 0;
                        a_done = 1'b0;
                    end
                    if (a_cnt < MAX_TERMS)
                    begin
                        a_terms[a_cnt] = coef;
                        a_cnt++;
                    end
                    else
                        dropped = 1'b1;
                    if (last_term)
                        a_done = 1'b1;
                end
                else
                begin
                    if (b_cnt < MAX_TERMS)
                    begin
                        b_terms[b_cnt] = coef;
                        b_cnt++;
                    end
                    else
                        dropped = 1'b1;

                    if (last_term)
                    begin
                        // an empty operand counts as the single term zero
                        a_zero = (a_cnt == 0);
                        b_zero = (b_cnt == 0);
                        na     = a_zero ? 1 : a_cnt;
                        nb     = b_zero ? 1 : b_cnt;
                        nterms = na + nb - 1;
                        for (int k = 0; k < nterms; k++)
                        begin
                            acc = 0;
                            for (int i = 0; i < na; i++)
                            begin
                                j = k - i;
                                if (j >= 0 && j < nb && !a_zero && !b_zero)
                                    acc += longint'(a_terms[i]) * longint'(b_terms[j]);
                            end
                            want.value   = acc[PROD_W-1:0];
                            want.power   = POWER_W'(k);
                            want.is_last = (k == nterms - 1);
                            want.trunc   = dropped;
                            product_q.push_back(want);
                        end
                        a_cnt   = 0;
                        b_cnt   = 0;
                        a_done  = 1'b0;
                        dropped = 1'b0;
                    end
                end
            end

            if (out_valid && !out_stall)
            begin
                got = '{product_coefficient, power, last_result, truncated};
                if (product_q.size() == 0)
                    report_mismatch("unexpected result", '0, got);
                else
                begin
                    want = product_q.pop_front();
                    if (got.value !== want.value || got.power !== want.power ||
                        got.is_last !== want.is_last || got.trunc !== want.trunc)
                        report_mismatch("mismatch", want, got);
                end
            end

            pending <= product_q.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the polynomial multiplier: clock, reset, item stimulus, stall pattern, verdict.
module testbench;

    import pmul_pkg::*;

    localparam logic [IN_COEF_W-1:0] COEF_MIN = {1'b1, {(IN_COEF_W-1){1'b0}}};
    localparam logic [IN_COEF_W-1:0] COEF_MAX = {1'b0, {(IN_COEF_W-1){1'b1}}};
    localparam int                   NUM_ITEMS = 400;

    typedef enum int {
        FILL_RANDOM,
        FILL_MIN,
        FILL_MAX
    } fill_t;

    typedef enum int {
        SEQ_PLAIN,
        SEQ_NO_A,
        SEQ_A_RESTART,
        SEQ_INTERLEAVED,
        SEQ_OVERFLOW
    } seq_kind_t;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        func;
    logic signed [IN_COEF_W-1:0] coefficient;
    logic                        last_term;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [PROD_W-1:0]    product_coefficient;
    logic [POWER_W-1:0]          power;
    logic                        last_result;
    logic                        truncated;

    int          fail_count;
    int          pending;
    int          items_sent;
    int          burst_left;
    int          stall_left;
    int          stall_tick;
    int          stall_period;
    stall_mode_t stall_mode;
    seq_kind_t   seq_kind;
    int          draw;
    int          na;
    int          nb;
    int          ra;
    int          rb;
    bit          mark;

    polynomial_multiply_top i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .func                (func),
        .coefficient         (coefficient),
        .last_term           (last_term),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .product_coefficient (product_coefficient),
        .power               (power),
        .last_result         (last_result),
        .truncated           (truncated)
    );

    pmul_checker i_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .func                (func),
        .coefficient         (coefficient),
        .last_term           (last_term),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .product_coefficient (product_coefficient),
        .power               (power),
        .last_result         (last_result),
        .truncated           (truncated),
        .fail_count          (fail_count),
        .pending             (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode  = STALL_NONE;
            stall_left  = 0;
            stall_tick  = 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode   = stall_mode_t'($urandom_range(0, 3));
                stall_left   = $urandom_range(20, 200);
                stall_period = $urandom_range(2, 7);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_HALF:     out_stall <= ($urandom_range(0, 1) == 1);
                STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: out_stall <= ((stall_tick % stall_period) == 0);
                default:        out_stall <= 1'b0;
            endcase
        end
    end

    function automatic logic [IN_COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return COEF_MIN;
            1:       return COEF_MAX;
            2:       return '0;
            3:       return '1;
            4:       return IN_COEF_W'($urandom_range(0, 15));
            default: return IN_COEF_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input bit f, input logic [IN_COEF_W-1:0] c, input bit is_last);
        func        <= f;
        coefficient <= c;
        last_term   <= is_last;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic send_operand(input bit f, input int n, input bit mark_last, input fill_t fill);
        logic [IN_COEF_W-1:0] c;
        for (int i = 0; i < n; i++)
        begin
            case (fill)
                FILL_MIN: c = COEF_MIN;
                FILL_MAX: c = COEF_MAX;
                default:  c = pick_coef();
            endcase
            send_item(f, c, mark_last && (i == n - 1));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = 1'b0;
        coefficient = '0;
        last_term   = 1'b0;
        items_sent  = 0;
        burst_left  = $urandom_range(1, 10);
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // operand A never loaded
        send_item(1'b1, IN_COEF_W'(5), 1'b1);
        send_item(1'b1, IN_COEF_W'(9), 1'b0);
        send_item(1'b1, -IN_COEF_W'(9), 1'b1);
        // field extremes
        send_item(1'b0, COEF_MAX, 1'b0);
        send_item(1'b0, COEF_MIN, 1'b1);
        send_item(1'b1, COEF_MIN, 1'b0);
        send_item(1'b1, COEF_MAX, 1'b1);
        send_item(1'b0, '1, 1'b1);
        send_item(1'b1, '1, 1'b1);
        // new A after A's last mark
        send_item(1'b0, IN_COEF_W'(3), 1'b1);
        send_item(1'b0, IN_COEF_W'(4), 1'b0);
        send_item(1'b0, IN_COEF_W'(5), 1'b1);
        send_item(1'b1, IN_COEF_W'(6), 1'b1);
        // B ends before A's last mark
        send_item(1'b0, IN_COEF_W'(2), 1'b0);
        send_item(1'b1, IN_COEF_W'(7), 1'b1);
        // interleaved operands
        send_item(1'b0, IN_COEF_W'(1), 1'b0);
        send_item(1'b1, IN_COEF_W'(2), 1'b0);
        send_item(1'b0, IN_COEF_W'(3), 1'b1);
        send_item(1'b1, IN_COEF_W'(4), 1'b1);

        while (items_sent < NUM_ITEMS)
        begin
            draw = $urandom_range(0, 15);
            if (draw < 10)
                seq_kind = SEQ_PLAIN;
            else if (draw == 10)
                seq_kind = SEQ_NO_A;
            else if (draw == 11)
                seq_kind = SEQ_A_RESTART;
            else if (draw < 15)
                seq_kind = SEQ_INTERLEAVED;
            else
                seq_kind = SEQ_OVERFLOW;

            na = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            nb = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);

            case (seq_kind)
                SEQ_PLAIN:
                begin
                    send_operand(1'b0, na, 1'b1, FILL_RANDOM);
                    send_operand(1'b1, nb, 1'b1, FILL_RANDOM);
                end
                SEQ_NO_A:
                    send_operand(1'b1, nb, 1'b1, FILL_RANDOM);
                SEQ_A_RESTART:
                begin
                    send_operand(1'b0, $urandom_range(1, 5), 1'b1, FILL_RANDOM);
                    send_operand(1'b0, $urandom_range(1, 5), ($urandom_range(0, 1) == 1),
                                 FILL_RANDOM);
                    send_operand(1'b1, nb, 1'b1, FILL_RANDOM);
                end
                SEQ_INTERLEAVED:
                begin
                    ra   = na;
                    rb   = nb - 1;
                    mark = ($urandom_range(0, 1) == 1);
                    while (ra + rb > 0)
                    begin
                        if (rb == 0 || (ra > 0 && $urandom_range(0, 1) == 1))
                        begin
                            send_item(1'b0, pick_coef(), mark && (ra == 1));
                            ra--;
                        end
                        else
                        begin
                            send_item(1'b1, pick_coef(), 1'b0);
                            rb--;
                        end
                    end
                    send_item(1'b1, pick_coef(), 1'b1);
                end
                SEQ_OVERFLOW:
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            send_operand(1'b0, $urandom_range(33, 36), 1'b1, FILL_RANDOM);
                            send_operand(1'b1, $urandom_range(1, 3), 1'b1, FILL_RANDOM);
                        end
                        1:
                        begin
                            send_operand(1'b0, $urandom_range(1, 3), 1'b1, FILL_RANDOM);
                            send_operand(1'b1, $urandom_range(33, 36), 1'b1, FILL_RANDOM);
                        end
                        2:
                        begin
                            send_operand(1'b0, 33, 1'b1, FILL_MIN);
                            send_operand(1'b1, 32, 1'b1, FILL_MIN);
                        end
                        default:
                        begin
                            send_operand(1'b0, 32, 1'b1, FILL_MAX);
                            send_operand(1'b1, 33, 1'b1, FILL_MIN);
                        end
                    endcase
                end
                default:
                    send_operand(1'b1, 1, 1'b1, FILL_RANDOM);
            endcase
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
